[hdl/mfv_pkg.sv]
// ============================================================================
// mfv_pkg - shared types and constants for the message field validator
// Field type codes, error codes, date length codes and the record that the
// front end hands to the back end for every finished field.
// ============================================================================
package mfv_pkg;

    localparam int MAX_DATE_DIGITS = 12;
    localparam int CNT_W           = 4;

    localparam logic [CNT_W-1:0] COUNT_SAT     = CNT_W'(13);
    localparam logic [CNT_W-1:0] DATE_LEN_YM   = CNT_W'(4);
    localparam logic [CNT_W-1:0] DATE_LEN_MDHM = CNT_W'(10);
    localparam logic [CNT_W-1:0] DATE_LEN_FULL = CNT_W'(MAX_DATE_DIGITS);

    // field types
    localparam logic [2:0] TYPE_BCD       = 3'd0;
    localparam logic [2:0] TYPE_DIGITS    = 3'd1;
    localparam logic [2:0] TYPE_ALNUM     = 3'd2;
    localparam logic [2:0] TYPE_PRINTABLE = 3'd3;
    localparam logic [2:0] TYPE_ALNUM_SP  = 3'd4;
    localparam logic [2:0] TYPE_DATETIME  = 3'd5;

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_CHAR  = 2'd1;
    localparam logic [1:0] ERR_DATE  = 2'd2;
    localparam logic [1:0] ERR_SPACE = 2'd3;

    typedef logic [MAX_DATE_DIGITS-1:0][3:0] digits_t;

    // one finished field, ready for judgment
    typedef struct packed {
        logic             empty;
        logic [2:0]       ftype;
        logic [CNT_W-1:0] count;
        logic             bad_char;
        logic             only_space;
        digits_t          digits;
    } mfv_rec_t;

endpackage

[hdl/message_field_validator.sv]
// ============================================================================
// message_field_validator - streaming message field checker
// Validates one field, fed a byte per beat, and reports pass/fail per field.
// ============================================================================
// The block takes one input beat every clock cycle while in_stall is low. The
// beat flagged first picks the field type from cmd (packed BCD, digits,
// letters and digits, printable or tab, letters/digits/whitespace, or
// date-time YYMM, MMDDhhmmss, YYMMDDhhmmss). A beat flagged last, or any beat
// with empty_field set, closes the field and yields exactly one result beat
// (field_ok, error_code); other beats yield nothing. Beats without first keep
// extending the open field, or open a new one of the previously latched type
// after a field end. The front end classifies each byte and drops a record for
// every closed field into a two-entry queue; the back end judges the record
// (empty fields first, then character errors, then whitespace-only, then
// date/length) into an output register. A result is registered first in the
// queue entry and then in the output register. in_stall rises only when both
// queue entries are occupied, i.e. when the result side has held out_stall
// long enough for two closed fields to pile up; with out_stall low the
// sustained rate is one beat per cycle, including one closed field per cycle.
// ============================================================================
module message_field_validator (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] cmd,
    input  logic [7:0] data_byte,
    input  logic       first,
    input  logic       last,
    input  logic       empty_field,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       field_ok,
    output logic [1:0] error_code
);
    import mfv_pkg::*;

    // front -> queue
    logic     push;
    mfv_rec_t push_rec;
    logic     q_full;

    // queue -> back
    logic     pop;
    logic     head_valid;
    mfv_rec_t head_rec;

    mfv_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .first       (first),
        .last        (last),
        .empty_field (empty_field),
        .q_full      (q_full),
        .push        (push),
        .push_rec    (push_rec)
    );

    mfv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_rec   (push_rec),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    // back end owns the output register; results leave in queue order
    mfv_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .field_ok   (field_ok),
        .error_code (error_code)
    );

endmodule

[hdl/mfv_front.sv]
// ============================================================================
// mfv_front - byte intake and character classification
// Takes one beat per cycle unless the queue is full, tracks the field in
// progress and emits a record to the queue on the last byte or an empty field.
// ============================================================================
module mfv_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [2:0]        cmd,
    input  logic [7:0]        data_byte,
    input  logic              first,
    input  logic              last,
    input  logic              empty_field,
    input  logic              q_full,
    output logic              push,
    output mfv_pkg::mfv_rec_t push_rec
);
    import mfv_pkg::*;

    logic [2:0]       type_reg;
    logic [CNT_W-1:0] count_reg;
    logic             bad_reg;
    logic             only_reg;
    logic [3:0]       digit_reg [MAX_DATE_DIGITS];

    logic             accept;
    logic [2:0]       eff_type;
    logic [CNT_W-1:0] base_count;
    logic             base_bad;
    logic             base_only;
    logic             byte_ok;
    logic             is_sp;
    logic             is_dig;
    logic             is_alnum;
    logic             dig_we;
    logic [CNT_W-1:0] count_next;
    logic             bad_next;
    logic             only_next;
    digits_t          digits_next;

    assign in_stall = q_full;
    assign accept   = in_valid & ~q_full;
    assign push     = accept & (last | empty_field);

    always_comb
    begin
        eff_type   = first ? cmd : type_reg;
        base_count = first ? '0 : count_reg;
        base_bad   = first ? 1'b0 : bad_reg;
        base_only  = first ? 1'b1 : only_reg;

        is_dig   = (data_byte >= 8'd48) && (data_byte <= 8'd57);
        is_alnum = is_dig || ((data_byte >= 8'd65) && (data_byte <= 8'd90))
                   || ((data_byte >= 8'd97) && (data_byte <= 8'd122));
        is_sp    = ((data_byte >= 8'd9) && (data_byte <= 8'd13)) || (data_byte == 8'd32);

        case (eff_type)
            TYPE_BCD:       byte_ok = (data_byte[7:4] <= 4'd9) && (data_byte[3:0] <= 4'd9);
            TYPE_DIGITS:    byte_ok = is_dig;
            TYPE_ALNUM:     byte_ok = is_alnum;
            TYPE_PRINTABLE: byte_ok = ((data_byte >= 8'd32) && (data_byte <= 8'd126))
                                      || (data_byte == 8'd9);
            TYPE_ALNUM_SP:  byte_ok = is_alnum || is_sp;
            TYPE_DATETIME:  byte_ok = is_dig;
            default:        byte_ok = 1'b0;
        endcase

        bad_next   = base_bad | ~byte_ok;
        only_next  = base_only & is_sp;
        count_next = (base_count < COUNT_SAT) ? base_count + CNT_W'(1) : base_count;
        dig_we     = (eff_type == TYPE_DATETIME) && byte_ok && (base_count < DATE_LEN_FULL);

        // digit value is the low nibble of an ASCII digit
        for (int i = 0; i < MAX_DATE_DIGITS; i++)
        begin
            digits_next[i] = digit_reg[i];
        end
        if (dig_we)
        begin
            digits_next[base_count] = data_byte[3:0];
        end
    end

    always_comb
    begin
        push_rec.empty      = empty_field;
        push_rec.ftype      = eff_type;
        push_rec.count      = count_next;
        push_rec.bad_char   = bad_next;
        push_rec.only_space = only_next;
        push_rec.digits     = digits_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg  <= TYPE_BCD;
            count_reg <= '0;
            bad_reg   <= 1'b0;
            only_reg  <= 1'b1;
        end
        else if (accept)
        begin
            type_reg <= eff_type;
            if (empty_field || last)
            begin
                count_reg <= '0;
                bad_reg   <= 1'b0;
                only_reg  <= 1'b1;
            end
            else
            begin
                count_reg <= count_next;
                bad_reg   <= bad_next;
                only_reg  <= only_next;
            end
        end
    end

    // digit store: no reset, only entries written in the current field are judged
    always_ff @(posedge clk)
    begin
        if (accept && !empty_field && dig_we)
        begin
            digit_reg[base_count] <= data_byte[3:0];
        end
    end

    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_SAT)
        else $error("front: byte count beyond saturation");

    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (count_reg == '0) && !bad_reg && only_reg)
        else $error("front: field state not cleared after field end");

    a_push_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("front: record pushed into full queue");

endmodule

[hdl/mfv_queue.sv]
// ============================================================================
// mfv_queue - two-entry record queue
// Decouples the byte intake from result delivery.
// ============================================================================
module mfv_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mfv_pkg::mfv_rec_t push_rec,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output mfv_pkg::mfv_rec_t head_rec
);
    import mfv_pkg::*;

    localparam int DEPTH = 2;

    mfv_rec_t   entry_reg [DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign full       = (cnt_reg == 2'(DEPTH));
    assign head_valid = (cnt_reg != 2'd0);
    assign head_rec   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(DEPTH))
        else $error("queue: occupancy out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue: push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue: pop while empty");

endmodule

[hdl/mfv_back.sv]
// ============================================================================
// mfv_back - field judgment and result register
// Turns a finished field record into field_ok / error_code, including the
// date-time range checks, and holds the result until it is taken.
// ============================================================================
module mfv_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  mfv_pkg::mfv_rec_t head_rec,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              field_ok,
    output logic [1:0]        error_code
);
    import mfv_pkg::*;

    logic       out_valid_reg;
    logic       field_ok_reg;
    logic [1:0] error_code_reg;

    logic [6:0] yy;
    logic [6:0] mo;
    logic [6:0] dd;
    logic [6:0] hh;
    logic [6:0] mi;
    logic [6:0] ss;
    logic [6:0] mo_ym;
    logic [6:0] lim;
    logic       with_year;
    logic       mdhms_ok;
    logic       date_ok;
    logic [1:0] code;

    function automatic logic [6:0] pair(input logic [3:0] hi, input logic [3:0] lo);
        pair = 7'(hi) * 7'd10 + 7'(lo);
    endfunction

    always_comb
    begin
        with_year = (head_rec.count == DATE_LEN_FULL);
        yy        = pair(head_rec.digits[0], head_rec.digits[1]);
        mo_ym     = pair(head_rec.digits[2], head_rec.digits[3]);
        if (with_year)
        begin
            mo = pair(head_rec.digits[2],  head_rec.digits[3]);
            dd = pair(head_rec.digits[4],  head_rec.digits[5]);
            hh = pair(head_rec.digits[6],  head_rec.digits[7]);
            mi = pair(head_rec.digits[8],  head_rec.digits[9]);
            ss = pair(head_rec.digits[10], head_rec.digits[11]);
        end
        else
        begin
            mo = pair(head_rec.digits[0], head_rec.digits[1]);
            dd = pair(head_rec.digits[2], head_rec.digits[3]);
            hh = pair(head_rec.digits[4], head_rec.digits[5]);
            mi = pair(head_rec.digits[6], head_rec.digits[7]);
            ss = pair(head_rec.digits[8], head_rec.digits[9]);
        end

        // February: leap rule on two-digit year only when a year is present
        case (mo)
            7'd4, 7'd6, 7'd9, 7'd11: lim = 7'd30;
            7'd2:                    lim = (with_year && (yy[1:0] != 2'd0)) ? 7'd28 : 7'd29;
            default:                 lim = 7'd31;
        endcase

        mdhms_ok = (mo >= 7'd1) && (mo <= 7'd12) && (dd >= 7'd1) && (dd <= lim)
                   && (hh <= 7'd23) && (mi <= 7'd59) && (ss <= 7'd59);

        if (head_rec.count == DATE_LEN_YM)
        begin
            date_ok = (mo_ym >= 7'd1) && (mo_ym <= 7'd12);
        end
        else if ((head_rec.count == DATE_LEN_MDHM) || with_year)
        begin
            date_ok = mdhms_ok;
        end
        else
        begin
            date_ok = 1'b0;
        end

        if (head_rec.empty)
        begin
            code = ERR_DATE;
        end
        else if (head_rec.bad_char)
        begin
            code = ERR_CHAR;
        end
        else if ((head_rec.ftype == TYPE_ALNUM_SP) && head_rec.only_space)
        begin
            code = ERR_SPACE;
        end
        else if ((head_rec.ftype == TYPE_DATETIME) && !date_ok)
        begin
            code = ERR_DATE;
        end
        else
        begin
            code = ERR_NONE;
        end
    end

    assign pop        = head_valid & (~out_valid_reg | ~out_stall);
    assign out_valid  = out_valid_reg;
    assign field_ok   = field_ok_reg;
    assign error_code = error_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            field_ok_reg   <= (code == ERR_NONE);
            error_code_reg <= code;
        end
    end

    a_ok_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (field_ok_reg == (error_code_reg == ERR_NONE)))
        else $error("back: field_ok disagrees with error_code");

    a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg)
        else $error("back: popped record produced no result");

    a_empty_fails: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head_rec.empty) |=> (error_code_reg == ERR_DATE))
        else $error("back: empty field not rejected");

endmodule

[dv/tb_message_field_validator.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_message_field_validator - self-checking bench for the field validator
// Streams message fields (directed corner cases, then constrained-by-hand
// random fields) through the block with random idles and back-pressure, and
// checks every result beat against an in-bench model of the field rules.
// ============================================================================
module tb_message_field_validator;

    import mfv_pkg::*;

    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 5;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 20;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int RANDOM_BEATS_A   = 1100;
    localparam int RANDOM_BEATS_B   = 850;

    // type codes with no character class behind them
    localparam logic [2:0] TYPE_SPARE6 = 3'd6;
    localparam logic [2:0] TYPE_SPARE7 = 3'd7;

    // character codes
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_NINE    = 8'd57;
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_Z = 8'd90;
    localparam logic [7:0] CH_LOWER_A = 8'd97;
    localparam logic [7:0] CH_LOWER_Z = 8'd122;
    localparam logic [7:0] CH_TILDE   = 8'd126;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] data_byte;
        logic       first;
        logic       last;
        logic       empty_field;
    } beat_t;

    typedef struct packed {
        logic       field_ok;
        logic [1:0] error_code;
    } verdict_t;

    typedef logic [7:0] byte_q_t [$];

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    beat_t      in_beat   = '0;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic       field_ok;
    logic [1:0] error_code;

    message_field_validator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (in_beat.cmd),
        .data_byte   (in_beat.data_byte),
        .first       (in_beat.first),
        .last        (in_beat.last),
        .empty_field (in_beat.empty_field),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .field_ok    (field_ok),
        .error_code  (error_code)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    beat_t       beat_feed[$];      // beats waiting to be driven
    verdict_t    verdicts_due[$];   // results owed by the block, oldest first
    int unsigned beats_queued   = 0;
    int unsigned beats_sent     = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned rx_cycles      = 0;
    int unsigned send_gap       = 0;
    int unsigned stall_left     = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned stall_idle_pct = 0;
    bit          beat_taken     = 1'b0;  // input beat accepted at last rising edge
    bit          steady_phase   = 1'b0;  // no idles on either side
    bit          hold_go        = 1'b0;
    bit          long_hold      = 1'b0;

    // Field tracker: mirrors what the block holds for the open field.
    logic [2:0]       cur_type  = TYPE_BCD;
    logic [CNT_W-1:0] byte_cnt  = '0;
    logic             bad_seen  = 1'b0;
    logic             all_space = 1'b1;
    logic [3:0]       date_digits [MAX_DATE_DIGITS];

    // ------------------------------------------------------------------------
    // Field rules
    // ------------------------------------------------------------------------
    function automatic logic is_digit(input logic [7:0] v);
        return v >= CH_ZERO && v <= CH_NINE;
    endfunction

    function automatic logic is_alnum(input logic [7:0] v);
        return is_digit(v) || (v >= CH_UPPER_A && v <= CH_UPPER_Z)
            || (v >= CH_LOWER_A && v <= CH_LOWER_Z);
    endfunction

    function automatic logic is_ws(input logic [7:0] v);
        return (v >= CH_TAB && v <= CH_CR) || v == CH_SPACE;
    endfunction

    function automatic logic byte_fits(input logic [2:0] t, input logic [7:0] v);
        case (t)
            TYPE_BCD:       return v[7:4] <= 4'd9 && v[3:0] <= 4'd9;
            TYPE_DIGITS:    return is_digit(v);
            TYPE_ALNUM:     return is_alnum(v);
            TYPE_PRINTABLE: return (v >= CH_SPACE && v <= CH_TILDE) || v == CH_TAB;
            TYPE_ALNUM_SP:  return is_alnum(v) || is_ws(v);
            TYPE_DATETIME:  return is_digit(v);
            default:        return 1'b0;
        endcase
    endfunction

    function automatic int unsigned dpair(input int unsigned p);
        return int'(date_digits[p]) * 10 + int'(date_digits[p + 1]);
    endfunction

    // MMDDhhmmss starting at digit p; the year, when present, sits at digit 0
    function automatic logic mdhms_ok(input int unsigned p, input logic has_year);
        int unsigned mo;
        int unsigned dd;
        int unsigned lim;
        mo = dpair(p);
        dd = dpair(p + 2);
        if (mo < 1 || mo > 12)
            return 1'b0;
        if (mo == 4 || mo == 6 || mo == 9 || mo == 11)
            lim = 30;
        else if (mo == 2)
            lim = (has_year && dpair(0) % 4 != 0) ? 28 : 29;
        else
            lim = 31;
        return dd >= 1 && dd <= lim && dpair(p + 4) <= 23
            && dpair(p + 6) <= 59 && dpair(p + 8) <= 59;
    endfunction

    function automatic logic date_ok();
        int unsigned mo;
        case (byte_cnt)
            DATE_LEN_YM:
            begin
                mo = dpair(2);
                return mo >= 1 && mo <= 12;
            end
            DATE_LEN_MDHM: return mdhms_ok(0, 1'b0);
            DATE_LEN_FULL: return mdhms_ok(2, 1'b1);
            default:       return 1'b0;
        endcase
    endfunction

    task automatic restart_field();
        byte_cnt  = '0;
        bad_seen  = 1'b0;
        all_space = 1'b1;
    endtask

    // Fold one accepted beat into the open field; queue a verdict if it closes.
    task automatic validate_beat(input beat_t b);
        verdict_t   v;
        logic       fits;
        logic [1:0] code;
        if (b.first)
        begin
            cur_type = b.cmd;
            restart_field();
        end
        if (b.empty_field)
        begin
            // zero-length field: always a date/length error, last is moot
            restart_field();
            v.field_ok   = 1'b0;
            v.error_code = ERR_DATE;
            verdicts_due.push_back(v);
        end
        else
        begin
            fits = byte_fits(cur_type, b.data_byte);
            if (!fits)
                bad_seen = 1'b1;
            if (!is_ws(b.data_byte))
                all_space = 1'b0;
            if (cur_type == TYPE_DATETIME && fits && byte_cnt < MAX_DATE_DIGITS)
                date_digits[byte_cnt] = 4'(b.data_byte - CH_ZERO);
            if (byte_cnt < COUNT_SAT)
                byte_cnt = byte_cnt + 1'b1;
            if (b.last)
            begin
                // bad character beats whitespace-only beats date checks
                if (bad_seen)
                    code = ERR_CHAR;
                else if (cur_type == TYPE_ALNUM_SP && all_space)
                    code = ERR_SPACE;
                else if (cur_type == TYPE_DATETIME && !date_ok())
                    code = ERR_DATE;
                else
                    code = ERR_NONE;
                restart_field();
                v.field_ok   = (code == ERR_NONE);
                v.error_code = code;
                verdicts_due.push_back(v);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    function automatic int unsigned pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 5;
            default: return 20;
        endcase
    endfunction

    // dates weighted double, spare types rare
    function automatic logic [2:0] random_type();
        int unsigned r;
        r = $urandom_range(0, 49);
        if (r == 0)
            return TYPE_SPARE6;
        if (r == 1)
            return TYPE_SPARE7;
        return (r % 7 == 6) ? TYPE_DATETIME : 3'(r % 7);
    endfunction

    function automatic logic [7:0] space_byte();
        int unsigned r;
        r = $urandom_range(8, 13);
        return (r == 8) ? CH_SPACE : 8'(r);
    endfunction

    function automatic logic [7:0] alnum_byte();
        case ($urandom_range(0, 2))
            0:       return CH_ZERO + 8'($urandom_range(0, 9));
            1:       return CH_UPPER_A + 8'($urandom_range(0, 25));
            default: return CH_LOWER_A + 8'($urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [7:0] good_byte(input logic [2:0] t);
        case (t)
            TYPE_BCD:       return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
            TYPE_DIGITS,
            TYPE_DATETIME:  return CH_ZERO + 8'($urandom_range(0, 9));
            TYPE_ALNUM:     return alnum_byte();
            TYPE_PRINTABLE: return ($urandom_range(0, 15) == 0) ? CH_TAB
                                 : 8'($urandom_range(32, 126));
            TYPE_ALNUM_SP:  return ($urandom_range(0, 3) == 0) ? space_byte() : alnum_byte();
            default:        return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly legal, now and then just past the limit or wildly out
    function automatic int unsigned date_value(input int unsigned lim);
        case ($urandom_range(0, 15))
            0:       return $urandom_range(lim + 1, 99);
            1:       return lim;
            default: return $urandom_range(0, lim);
        endcase
    endfunction

    function automatic byte_q_t text_bytes(input string s);
        byte_q_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    task automatic add_pair(ref byte_q_t q, input int unsigned v);
        q.push_back(CH_ZERO + 8'(v / 10));
        q.push_back(CH_ZERO + 8'(v % 10));
    endtask

    task automatic make_date(ref byte_q_t body);
        int unsigned yy;
        int unsigned mo;
        int unsigned dd;
        int unsigned shape;
        yy = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0:       mo = $urandom_range(0, 1) ? 0 : $urandom_range(13, 99);
            1, 2:    mo = 2;
            default: mo = $urandom_range(1, 12);
        endcase
        case ($urandom_range(0, 7))
            0:       dd = 0;
            1:       dd = 28;
            2:       dd = 29;
            3:       dd = 30;
            4:       dd = 31;
            5:       dd = $urandom_range(32, 99);
            default: dd = $urandom_range(1, 27);
        endcase
        shape = $urandom_range(0, 9);
        if (shape <= 2)
        begin
            add_pair(body, yy);
            add_pair(body, mo);
        end
        else if (shape <= 8)
        begin
            if (shape >= 6)
                add_pair(body, yy);
            add_pair(body, mo);
            add_pair(body, dd);
            add_pair(body, date_value(23));
            add_pair(body, date_value(59));
            add_pair(body, date_value(59));
        end
        else
        begin
            // odd lengths, past saturation included
            repeat ($urandom_range(1, 16))
                body.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    task automatic make_body(input logic [2:0] t, ref byte_q_t body);
        int unsigned n;
        bit          blanks;
        body = {};
        if (t == TYPE_DATETIME)
            make_date(body);
        else
        begin
            n      = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 16) : $urandom_range(1, 8);
            blanks = (t == TYPE_ALNUM_SP) && ($urandom_range(0, 4) == 0);
            repeat (n)
                body.push_back(blanks ? space_byte() : good_byte(t));
        end
    endtask

    task automatic push_field(input logic [2:0] t, input byte_q_t body,
                              input bit with_first, input bit with_last);
        beat_t b;
        foreach (body[i])
        begin
            b.cmd         = (i == 0 && with_first) ? t : 3'($urandom_range(0, 5));
            b.data_byte   = body[i];
            b.first       = (i == 0) && with_first;
            b.last        = (i == body.size() - 1) && with_last;
            b.empty_field = 1'b0;
            beat_feed.push_back(b);
            beats_queued++;
        end
    endtask

    task automatic push_empty(input bit with_first, input logic [2:0] t);
        beat_t b;
        b.cmd         = t;
        b.data_byte   = 8'($urandom_range(0, 255));
        b.first       = with_first;
        b.last        = 1'($urandom_range(0, 1));
        b.empty_field = 1'b1;
        beat_feed.push_back(b);
        beats_queued++;
    endtask

    task automatic push_directed();
        byte_q_t txt;
        push_empty(1'b1, TYPE_DATETIME);      // empty with first: latches type
        push_empty(1'b0, TYPE_BCD);           // empty without first
        txt = {8'h9A};                        // BCD low nibble out of range
        push_field(TYPE_BCD, txt, 1'b1, 1'b1);
        txt = {8'hFF};
        push_field(TYPE_DIGITS, txt, 1'b1, 1'b1);
        txt = {CH_LOWER_Z};
        push_field(TYPE_ALNUM, txt, 1'b1, 1'b1);
        txt = {CH_TAB};
        push_field(TYPE_PRINTABLE, txt, 1'b1, 1'b1);
        txt = {CH_SPACE};                     // whitespace only
        push_field(TYPE_ALNUM_SP, txt, 1'b1, 1'b1);
        txt = {CH_SPACE, 8'h00};              // bad char wins over whitespace
        push_field(TYPE_ALNUM_SP, txt, 1'b1, 1'b1);
        txt = {CH_ZERO};
        push_field(TYPE_SPARE6, txt, 1'b1, 1'b1);
        push_field(TYPE_SPARE7, txt, 1'b1, 1'b1);
        push_field(TYPE_DATETIME, text_bytes("2412"), 1'b1, 1'b1);
        push_field(TYPE_DATETIME, text_bytes("0229235959"), 1'b1, 1'b1);
        // no first after a closed field: opens a new date field of length 1
        push_field(TYPE_BCD, text_bytes("7"), 1'b0, 1'b1);
    endtask

    task automatic add_random_beats(input int unsigned goal);
        int unsigned start;
        int unsigned kind;
        logic [2:0]  t;
        byte_q_t     body;
        start = beats_queued;
        while (beats_queued - start < goal)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                // well-formed field, sometimes with one byte spoiled
                t = random_type();
                make_body(t, body);
                if ($urandom_range(0, 6) == 0)
                    body[$urandom_range(0, body.size() - 1)] = 8'($urandom_range(0, 255));
                push_field(t, body, 1'b1, 1'b1);
            end
            else if (kind < 80)
                push_empty(1'($urandom_range(0, 1)), 3'($urandom_range(0, 5)));
            else if (kind < 90)
            begin
                // beats with no first byte
                make_body(3'($urandom_range(0, 5)), body);
                push_field(TYPE_BCD, body, 1'b0, $urandom_range(0, 3) != 0);
            end
            else
            begin
                // field cut short by whatever comes next
                t = random_type();
                make_body(t, body);
                push_field(t, body, 1'b1, 1'b0);
            end
        end
    endtask

    task automatic wait_drained();
        while (beat_feed.size() != 0 || in_valid || verdicts_due.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: new beat at the falling edge once the current one is taken
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!in_valid || beat_taken)
        begin
            if (send_gap != 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (beat_feed.size() != 0)
            begin
                in_beat  <= beat_feed.pop_front();
                in_valid <= 1'b1;
                beats_sent++;
                if (beats_sent % 128 == 0)
                    send_idle_pct = pick_idle_pct();
                // gap starts after this beat is taken
                if (!steady_phase && $urandom_range(0, 99) < send_idle_pct)
                    send_gap = $urandom_range(1, 17);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result side back-pressure: random bursts plus one long hold
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        rx_cycles++;
        if (rx_cycles % 64 == 0)
            stall_idle_pct = pick_idle_pct();
        if (stall_left != 0)
            stall_left--;
        else if (!steady_phase && $urandom_range(0, 99) < stall_idle_pct)
            stall_left = $urandom_range(1, 17);
        out_stall <= long_hold || stall_left != 0;
    end

    // Long hold: the sender keeps going, so the block fills and stalls its input.
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        long_hold = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitor: model the accepted input beat, then check any result beat
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        verdict_t want;
        beat_taken = in_valid && !in_stall;
        if (beat_taken)
            validate_beat(in_beat);
        if (out_valid && !out_stall)
        begin
            if (verdicts_due.size() == 0)
            begin
                $error("unexpected result beat: field_ok %0d error_code %0d",
                       field_ok, error_code);
                mismatch_count++;
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (field_ok !== want.field_ok)
                begin
                    $error("field_ok: expected %0d, got %0d", want.field_ok, field_ok);
                    mismatch_count++;
                end
                if (error_code !== want.error_code)
                begin
                    $error("error_code: expected %0d, got %0d", want.error_code, error_code);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_message_field_validator: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_directed();
        wait_drained();            // sender sits idle until every result is back

        add_random_beats(RANDOM_BEATS_A);
        hold_go = 1'b1;
        wait_drained();

        steady_phase = 1'b1;       // closing stretch at full rate
        add_random_beats(RANDOM_BEATS_B);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && verdicts_due.size() == 0)
            $display("tb_message_field_validator: clean");
        else
            $display("tb_message_field_validator: errors");
        $finish;
    end

endmodule
